### hdl/vector3_normalize_top_assert.svh
// ----------------------------------------------------------------------------
// vector3_normalize_top_assert.svh
// Assertion macros shared by the vector normalizer modules.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_NORMALIZE_TOP_ASSERT_SVH
`define VECTOR3_NORMALIZE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vector normalizer assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define VN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vector normalizer assertion failed");

`endif

### hdl/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// Widths and the queue transaction type of the vector normalizer.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int COMP_W     = 16;
  localparam int SQ_W       = 32;
  localparam int SUM_W      = 32;
  localparam int MAG_W      = 16;
  localparam int MAG_REM_W  = MAG_W + 2;
  localparam int IN_DATA_W  = 3 * COMP_W;
  localparam int OUT_DATA_W = 3 * COMP_W + MAG_W;

  localparam logic [COMP_W-1:0] UNIT_MAX = 16'h7FFF;

  // One classified vector: zero flag, signs, squared magnitudes, sum of squares.
  typedef struct packed {
    logic                  zero;
    logic [2:0]            neg;
    logic [SUM_W-1:0]      sum;
    logic [2:0][SQ_W-1:0]  sq;
  } vn_item_t;

endpackage

### hdl/vector3_normalize_top.sv
// Throughput: one vector per cycle while the result side does not stall; the
// back pipeline resolves one quotient bit or one root bit per stage for each
// component, so depth grows with FRAC_BITS while the issue rate stays one per cycle.
// Reset: synchronous, active low; clears valid bits and the queue count only.
// ----------------------------------------------------------------------------
// vector3_normalize_top
// Normalizes a signed 16-bit 3D vector to unit length, with its floor length.
// ----------------------------------------------------------------------------
module vector3_normalize_top #(
  parameter int FRAC_BITS = 14   // fraction bits of the unit components, 5..15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [vn_pkg::IN_DATA_W-1:0]  in_tdata,   // x_in, y_in, z_in
  // Result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [vn_pkg::OUT_DATA_W-1:0] out_tdata,  // x_unit, y_unit, z_unit, magnitude
  output logic                          out_tuser   // zero_vector
);
  import vn_pkg::*;

  // Front -> queue
  logic     push_valid, push_ready;
  vn_item_t push_item;
  // Queue -> back
  logic     pop_valid, pop_ready;
  vn_item_t pop_item;

  // Front: registers the transaction, forms squares, sum and zero flag.
  vn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Short queue so a stall on the result side does not reach the input at once.
  vn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Back: division, square roots and the output register.
  vn_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pop_valid),
    .in_ready   (pop_ready),
    .in_item    (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### hdl/vn_front.sv
// ----------------------------------------------------------------------------
// vn_front
// Input register, squares of the components and their sum.
// ----------------------------------------------------------------------------
module vn_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [vn_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                         push_valid,
  input  logic                         push_ready,
  output vn_pkg::vn_item_t             push_item
);
  import vn_pkg::*;

  logic                    f_v_r;
  logic [2:0][COMP_W-1:0]  comp_r;

  assign in_tready  = !f_v_r || push_ready;
  assign push_valid = f_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (in_tready) begin
      f_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      comp_r <= in_tdata;
    end
  end

  always_comb begin
    logic [COMP_W-1:0] mag;
    push_item = '0;
    for (int c = 0; c < 3; c++) begin
      mag = comp_r[c][COMP_W-1] ? (~comp_r[c] + 16'd1) : comp_r[c];
      push_item.neg[c] = comp_r[c][COMP_W-1];
      push_item.sq[c]  = SQ_W'(mag) * SQ_W'(mag);
    end
    push_item.sum  = push_item.sq[0] + push_item.sq[1] + push_item.sq[2];
    push_item.zero = (comp_r == '0);
  end

endmodule

### hdl/vn_queue.sv
// ----------------------------------------------------------------------------
// vn_queue
// Two-entry queue between the front and the back pipeline.
// ----------------------------------------------------------------------------
`include "vector3_normalize_top_assert.svh"

module vn_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  vn_pkg::vn_item_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output vn_pkg::vn_item_t pop_item
);
  import vn_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  vn_item_t   head_r, tail_r;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_item   = head_r;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push) begin
        head_r <= push_item;
      end else begin
        head_r <= tail_r;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        head_r <= push_item;
      end else begin
        tail_r <= push_item;
      end
    end
  end

  `VN_ASSERT_NEXT(a_full_drain, (cnt_r == 2'd2) && pop, cnt_r == 2'd1)
  `VN_ASSERT_NEXT(a_empty_fill, (cnt_r == 2'd0) && push, pop_valid)
  `VN_ASSERT_NOW(a_cnt_legal, 1'b1, cnt_r != 2'd3)

endmodule

### hdl/vn_back.sv
// ----------------------------------------------------------------------------
// vn_back
// Bit-per-stage pipeline: restoring division of each square by the sum,
// square root of each quotient, square root of the sum, output register.
// ----------------------------------------------------------------------------
`include "vector3_normalize_top_assert.svh"

module vn_back #(
  parameter int FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  vn_pkg::vn_item_t              in_item,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [vn_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tuser
);
  import vn_pkg::*;

  localparam int QW      = 2 * FRAC_BITS + 1;
  localparam int RW      = FRAC_BITS + 1;
  localparam int RREM_W  = RW + 2;
  localparam int DIV_STG = 2 * FRAC_BITS + 1;
  localparam int L       = DIV_STG + RW;
  localparam int MAXW    = (RW > COMP_W) ? RW : COMP_W;

  typedef struct packed {
    logic                    zero;
    logic [2:0]              neg;
    logic [SUM_W-1:0]        sum;
    logic [2:0][SQ_W-1:0]    rem;
    logic [2:0][QW-1:0]      quo;
    logic [2:0][RREM_W-1:0]  srem;
    logic [2:0][RW-1:0]      root;
    logic [MAG_REM_W-1:0]    mrem;
    logic [MAG_W-1:0]        mroot;
  } stg_t;

  stg_t  st_r [1:L];
  logic  v_r  [1:L];
  logic  en;

  logic                  out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;

  assign en       = !out_v_r || out_tready;
  assign in_ready = en;

  genvar k;
  for (k = 1; k <= L; k++) begin : g_stg
    stg_t p, a, n;
    logic pv;

    if (k == 1) begin : g_src_in
      always_comb begin
        p      = '0;
        p.zero = in_item.zero;
        p.neg  = in_item.neg;
        p.sum  = in_item.sum;
        p.rem  = in_item.sq;
      end
      assign pv = in_valid;
    end else begin : g_src_stg
      assign p  = st_r[k-1];
      assign pv = v_r[k-1];
    end

    if (k == 1) begin : g_div_init
      // square never exceeds the sum, so the leading quotient bit is 0 or 1
      always_comb begin
        a = p;
        for (int c = 0; c < 3; c++) begin
          if (p.rem[c] >= p.sum) begin
            a.rem[c] = p.rem[c] - p.sum;
            a.quo[c] = QW'(1);
          end
        end
      end
    end else if (k <= DIV_STG) begin : g_div
      always_comb begin
        logic [SQ_W:0] t;
        a = p;
        for (int c = 0; c < 3; c++) begin
          t = {p.rem[c], 1'b0};
          if (t >= {1'b0, p.sum}) begin
            a.rem[c] = SQ_W'(t - {1'b0, p.sum});
            a.quo[c] = {p.quo[c][QW-2:0], 1'b1};
          end else begin
            a.rem[c] = t[SQ_W-1:0];
            a.quo[c] = {p.quo[c][QW-2:0], 1'b0};
          end
        end
      end
    end else begin : g_sqrt
      localparam int PI = L - k;
      always_comb begin
        logic [2*RW-1:0]   qpad;
        logic [RREM_W-1:0] tr;
        logic [RREM_W-1:0] trial;
        a = p;
        for (int c = 0; c < 3; c++) begin
          qpad  = {1'b0, p.quo[c]};
          tr    = {p.srem[c][RW-1:0], qpad[2*PI+1 -: 2]};
          trial = {p.root[c], 2'b01};
          if (tr >= trial) begin
            a.srem[c] = tr - trial;
            a.root[c] = {p.root[c][RW-2:0], 1'b1};
          end else begin
            a.srem[c] = tr;
            a.root[c] = {p.root[c][RW-2:0], 1'b0};
          end
        end
      end
    end

    if (k <= MAG_W) begin : g_mag
      localparam int PM = MAG_W - k;
      always_comb begin
        logic [MAG_REM_W-1:0] mt;
        logic [MAG_REM_W-1:0] mtrial;
        n      = a;
        mt     = {a.mrem[MAG_W-1:0], a.sum[2*PM+1 -: 2]};
        mtrial = {a.mroot, 2'b01};
        if (mt >= mtrial) begin
          n.mrem  = mt - mtrial;
          n.mroot = {a.mroot[MAG_W-2:0], 1'b1};
        end else begin
          n.mrem  = mt;
          n.mroot = {a.mroot[MAG_W-2:0], 1'b0};
        end
      end
    end else begin : g_mag_hold
      assign n = a;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= n;
      end
    end
  end

  // saturate, apply sign, force zeros for the zero vector
  logic [2:0][COMP_W-1:0] unit_nxt;
  logic [MAG_W-1:0]       mag_nxt;

  always_comb begin
    logic [MAXW-1:0]   ext;
    logic [COMP_W-1:0] sat;
    for (int c = 0; c < 3; c++) begin
      ext = MAXW'(st_r[L].root[c]);
      sat = (ext > MAXW'(UNIT_MAX)) ? UNIT_MAX : ext[COMP_W-1:0];
      unit_nxt[c] = st_r[L].neg[c] ? (~sat + 16'd1) : sat;
      if (st_r[L].zero) begin
        unit_nxt[c] = '0;
      end
    end
    mag_nxt = st_r[L].zero ? '0 : st_r[L].mroot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[L];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {mag_nxt, unit_nxt};
      out_user_r <= st_r[L].zero;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `VN_ASSERT_NOW(a_zero_clears, out_v_r && out_user_r, out_data_r == '0)
  `VN_ASSERT_NOW(a_mag_nonzero, out_v_r && !out_user_r,
                 out_data_r[OUT_DATA_W-1 -: MAG_W] != '0)
  `VN_ASSERT_NEXT(a_out_hold, out_v_r && !out_tready,
                  out_v_r && $stable(out_data_r) && $stable(out_user_r))

endmodule
